/* rtl/onc_pkg.sv */
// Package for the oxygen Nernst concentration block.
// Holds register indexes, fixed-point constants, the pipeline word type and
// the radix-8 divider step. No dependencies.
package onc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_K_NOMINAL   = 3'd0;
    localparam logic [2:0] REG_T_NOMINAL   = 3'd1;
    localparam logic [2:0] REG_C_REFERENCE = 3'd2;
    localparam logic [2:0] REG_DE_MINIMUM  = 3'd3;
    localparam logic [2:0] REG_DE_MAXIMUM  = 3'd4;
    localparam logic [2:0] REG_T_MINIMUM   = 3'd5;
    localparam logic [2:0] REG_T_MAXIMUM   = 3'd6;

    // reset values
    localparam logic [23:0] K_NOMINAL_RST   = 24'd3126723;
    localparam logic [14:0] T_NOMINAL_RST   = 15'd15568;
    localparam logic [23:0] C_REFERENCE_RST = 24'd1369702;
    localparam logic [21:0] DE_MINIMUM_RST  = 22'h200000;
    localparam logic [21:0] DE_MAXIMUM_RST  = 22'h1FFFFF;
    localparam logic [14:0] T_MINIMUM_RST   = 15'd0;
    localparam logic [14:0] T_MAXIMUM_RST   = 15'd32767;

    // arithmetic constants
    localparam logic [20:0] LOG2E_SCALED = 21'd1586260;
    localparam logic [22:0] ZLIMIT       = 23'h400000;  // 64.0 in Q16
    localparam logic [29:0] POLY_C1      = 30'd746848465;
    localparam logic [27:0] POLY_C2      = 28'd242852024;
    localparam logic [26:0] POLY_C3      = 27'd83778192;
    localparam logic [30:0] POLY_ONE     = 31'h40000000;
    localparam logic [23:0] O2_MAX       = 24'hFFFFFF;

    // pipeline depth: input, 13 divider stages, 10 arithmetic stages
    localparam int DIV_STAGES = 13;
    localparam int NSTAGE     = 24;

    // one pipeline word; a and b are reused as working registers per stage
    typedef struct packed {
        logic        err;
        logic        neg;
        logic        tz;
        logic        sat;
        logic [14:0] t;
        logic [20:0] absde;
        logic [15:0] rem;
        logic [38:0] nq;
        logic [62:0] a;
        logic [62:0] b;
    } pipe_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [38:0] nq;
    } div_t;

    // three restoring division steps, quotient bits shift in at the bottom
    function automatic div_t div_step3(logic [15:0] rem_in, logic [38:0] nq_in,
                                       logic [14:0] d);
        div_t r;
        r.rem = rem_in;
        r.nq  = nq_in;
        for (int i = 0; i < 3; i++) begin
            r.rem = {r.rem[14:0], r.nq[38]};
            r.nq  = {r.nq[37:0], 1'b0};
            if (r.rem >= {1'b0, d}) begin
                r.rem   = r.rem - {1'b0, d};
                r.nq[0] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/oxygen_nernst_concentration_top.sv */
// Top level of the oxygen Nernst concentration block: config registers and
// a 24-stage pipeline (divider, exponent, scaling). Depends on onc_pkg.
//
// Usage:
//  - s_ channel: one word per sample; s_tdata holds cell_voltage [20:0],
//    offset_voltage [41:21], cell_temp [56:42], zeros above.
//  - m_ channel: one word per sample; m_tdata is o2_percent (Q8.16),
//    m_tuser is status (0 ok, 1 out of window, then o2_percent is 0).
//  - cfg port: write cfg_wdata to register cfg_addr when cfg_we is high;
//    write only while no sample is in flight.
//  - Flow: a word accepted at an edge fills the first of 24 registers, and
//    m_tvalid rises once it reaches the last; throughput is one word per
//    cycle while the receiver does not stall. Depth is set by the 13 radix-8 divider stages for
//    k_nominal*t_nominal/t plus the split multipliers and the cubic for 2^f.
//  - Reset (aresetn low, synchronous) empties the pipeline and loads the
//    default register values.
//  - When the receiver holds m_tready low with a word pending, the whole
//    pipeline holds and s_tready drops; nothing is lost or repeated.
module oxygen_nernst_concentration_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // cell_voltage, offset_voltage, cell_temp
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // o2_percent
    output logic        m_tuser,   // status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    logic [23:0] k_nominal_reg;
    logic [14:0] t_nominal_reg;
    logic [23:0] c_reference_reg;
    logic [21:0] de_minimum_reg;
    logic [21:0] de_maximum_reg;
    logic [14:0] t_minimum_reg;
    logic [14:0] t_maximum_reg;

    onc_pkg::pipe_t pipe_reg  [onc_pkg::NSTAGE];
    onc_pkg::pipe_t pipe_next [onc_pkg::NSTAGE];
    logic [onc_pkg::NSTAGE-1:0] vld_reg;
    logic [23:0] res_reg;
    logic [23:0] res_next;
    logic        en;

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_nominal_reg   <= onc_pkg::K_NOMINAL_RST;
            t_nominal_reg   <= onc_pkg::T_NOMINAL_RST;
            c_reference_reg <= onc_pkg::C_REFERENCE_RST;
            de_minimum_reg  <= onc_pkg::DE_MINIMUM_RST;
            de_maximum_reg  <= onc_pkg::DE_MAXIMUM_RST;
            t_minimum_reg   <= onc_pkg::T_MINIMUM_RST;
            t_maximum_reg   <= onc_pkg::T_MAXIMUM_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                onc_pkg::REG_K_NOMINAL:   k_nominal_reg   <= cfg_wdata;
                onc_pkg::REG_T_NOMINAL:   t_nominal_reg   <= cfg_wdata[14:0];
                onc_pkg::REG_C_REFERENCE: c_reference_reg <= cfg_wdata;
                onc_pkg::REG_DE_MINIMUM:  de_minimum_reg  <= cfg_wdata[21:0];
                onc_pkg::REG_DE_MAXIMUM:  de_maximum_reg  <= cfg_wdata[21:0];
                onc_pkg::REG_T_MINIMUM:   t_minimum_reg   <= cfg_wdata[14:0];
                onc_pkg::REG_T_MAXIMUM:   t_maximum_reg   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // advance whenever the output register is empty or being taken
    assign en       = !vld_reg[onc_pkg::NSTAGE-1] || m_tready;
    assign s_tready = en;

    // stage logic
    always_comb begin
        logic signed [21:0] de;
        logic [29:0]        fq;
        logic [7:0]         ipr;
        logic [6:0]         shift;
        logic [54:0]        shv;
        logic [38:0]        k;
        logic [62:0]        sum;
        logic [22:0]        y;
        onc_pkg::div_t      dv;

        // input stage: difference, window check, numerator
        de = 22'(signed'(s_tdata[20:0])) - 22'(signed'(s_tdata[41:21]));
        pipe_next[0]       = '0;
        pipe_next[0].t     = s_tdata[56:42];
        pipe_next[0].err   = (de < signed'(de_minimum_reg)) || (de > signed'(de_maximum_reg))
                           || (s_tdata[56:42] < t_minimum_reg)
                           || (s_tdata[56:42] > t_maximum_reg);
        pipe_next[0].neg   = (de > 22'sd0);
        pipe_next[0].tz    = (s_tdata[56:42] == 15'd0);
        pipe_next[0].absde = de[21] ? 21'(-de) : de[20:0];
        pipe_next[0].nq    = 39'(k_nominal_reg) * 39'(t_nominal_reg);

        // divider: three quotient bits per stage
        for (int i = 1; i <= onc_pkg::DIV_STAGES; i++) begin
            pipe_next[i]     = pipe_reg[i-1];
            dv               = onc_pkg::div_step3(pipe_reg[i-1].rem, pipe_reg[i-1].nq,
                                                  pipe_reg[i-1].t);
            pipe_next[i].rem = dv.rem;
            pipe_next[i].nq  = dv.nq;
        end

        // partial products of k * |de|
        pipe_next[14]   = pipe_reg[13];
        k               = pipe_reg[13].tz ? 39'(k_nominal_reg) : pipe_reg[13].nq;
        pipe_next[14].a = 63'(k[19:0] * 41'(pipe_reg[13].absde));
        pipe_next[14].b = 63'(k[38:20] * 40'(pipe_reg[13].absde));

        // sum products, flag magnitude overflow
        pipe_next[15]     = pipe_reg[14];
        sum               = pipe_reg[14].a + (pipe_reg[14].b << 20);
        pipe_next[15].sat = (sum[62:42] != '0);
        pipe_next[15].a   = {21'd0, sum[41:0]};

        // scale by log2(e), split into halves
        pipe_next[16]   = pipe_reg[15];
        pipe_next[16].a = 63'(pipe_reg[15].a[20:0] * 42'(onc_pkg::LOG2E_SCALED));
        pipe_next[16].b = 63'(pipe_reg[15].a[41:21] * 42'(onc_pkg::LOG2E_SCALED));

        // recombine, clamp exponent magnitude
        pipe_next[17] = pipe_reg[16];
        sum           = pipe_reg[16].a + (pipe_reg[16].b << 21);
        y             = sum[62:40];
        if (pipe_reg[16].sat || (y > onc_pkg::ZLIMIT)) begin
            y = onc_pkg::ZLIMIT;
        end
        pipe_next[17].a = 63'(y);

        // offset exponent by 64.0
        pipe_next[18]   = pipe_reg[17];
        pipe_next[18].a = pipe_reg[17].neg
                        ? 63'(24'(onc_pkg::ZLIMIT) - 24'(pipe_reg[17].a[22:0]))
                        : 63'(24'(onc_pkg::ZLIMIT) + 24'(pipe_reg[17].a[22:0]));

        // cubic for 2^f, Horner steps
        fq              = {pipe_reg[18].a[15:0], 14'd0};
        pipe_next[19]   = pipe_reg[18];
        pipe_next[19].b = 63'(onc_pkg::POLY_C2)
                        + 63'((57'(onc_pkg::POLY_C3) * 57'(fq)) >> 30);

        fq              = {pipe_reg[19].a[15:0], 14'd0};
        pipe_next[20]   = pipe_reg[19];
        pipe_next[20].b = 63'(onc_pkg::POLY_C1)
                        + 63'((60'(pipe_reg[19].b[30:0]) * 60'(fq)) >> 30);

        fq              = {pipe_reg[20].a[15:0], 14'd0};
        pipe_next[21]   = pipe_reg[20];
        pipe_next[21].b = 63'(onc_pkg::POLY_ONE)
                        + 63'((61'(pipe_reg[20].b[30:0]) * 61'(fq)) >> 30);

        // scale by reference concentration
        pipe_next[22]   = pipe_reg[21];
        pipe_next[22].b = 63'(55'(c_reference_reg) * 55'(pipe_reg[21].b[31:0]));

        // apply integer exponent and saturate; error words and a zero reference give zero
        pipe_next[23] = pipe_reg[22];
        ipr           = pipe_reg[22].a[23:16];
        shift         = 7'(8'd94 - ipr);
        shv           = pipe_reg[22].b[54:0] >> shift;
        if (pipe_reg[22].err || (c_reference_reg == 24'd0)) begin
            res_next = 24'd0;
        end else if (ipr > 8'd88) begin
            res_next = onc_pkg::O2_MAX;
        end else if (shv[54:24] != '0) begin
            res_next = onc_pkg::O2_MAX;
        end else begin
            res_next = shv[23:0];
        end
    end

    // advance pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < onc_pkg::NSTAGE; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
            res_reg <= res_next;
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[onc_pkg::NSTAGE-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[onc_pkg::NSTAGE-1];
    assign m_tdata  = res_reg;
    assign m_tuser  = pipe_reg[onc_pkg::NSTAGE-1].err;

    // an error word always carries zero concentration
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("error word with nonzero o2_percent");

    // a pending word is held while the receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word not captured");

endmodule

/* sim/tb.sv */
// Self-checking testbench for oxygen_nernst_concentration_top.
// Drives samples and register writes with random idling on both channels,
// predicts each result in a scoreboard class. Depends on onc_pkg and the RTL.
module tb;

    typedef struct {
        logic [23:0] o2;
        logic        status;
    } o2_result_t;

    // expected concentration words and the register copy they are computed from
    class o2_scoreboard;
        logic [23:0] k_nom, c_ref;
        logic [14:0] t_nom, t_min, t_max;
        logic [21:0] de_min, de_max;
        o2_result_t  pending[$];
        int          mismatches;

        function new();
            k_nom  = onc_pkg::K_NOMINAL_RST;
            t_nom  = onc_pkg::T_NOMINAL_RST;
            c_ref  = onc_pkg::C_REFERENCE_RST;
            de_min = onc_pkg::DE_MINIMUM_RST;
            de_max = onc_pkg::DE_MAXIMUM_RST;
            t_min  = onc_pkg::T_MINIMUM_RST;
            t_max  = onc_pkg::T_MAXIMUM_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                onc_pkg::REG_K_NOMINAL:   k_nom  = val;
                onc_pkg::REG_T_NOMINAL:   t_nom  = val[14:0];
                onc_pkg::REG_C_REFERENCE: c_ref  = val;
                onc_pkg::REG_DE_MINIMUM:  de_min = val[21:0];
                onc_pkg::REG_DE_MAXIMUM:  de_max = val[21:0];
                onc_pkg::REG_T_MINIMUM:   t_min  = val[14:0];
                onc_pkg::REG_T_MAXIMUM:   t_max  = val[14:0];
                default: ;
            endcase
        endfunction

        // 2^f for f in [0,1) Q16, cubic in Q30
        function logic [63:0] pow2_frac(logic [15:0] f16);
            logic [63:0] fq, acc;
            fq  = 64'(f16) << 14;
            acc = 64'(onc_pkg::POLY_C3);
            acc = 64'(onc_pkg::POLY_C2) + ((acc * fq) >> 30);
            acc = 64'(onc_pkg::POLY_C1) + ((acc * fq) >> 30);
            return (64'd1 << 30) + ((acc * fq) >> 30);
        endfunction

        function o2_result_t nernst(logic [20:0] cell_v, logic [20:0] offs, logic [14:0] t);
            o2_result_t  r;
            longint      de, ip, shift;
            logic [63:0] k, m, y, zo, v, res, absde;
            de = longint'($signed(cell_v)) - longint'($signed(offs));
            r.o2 = '0;
            r.status = 1'b1;
            if (de < longint'($signed(de_min)) || de > longint'($signed(de_max)) ||
                t < t_min || t > t_max)
                return r;
            k = (t == 0) ? 64'(k_nom) : (64'(k_nom) * 64'(t_nom)) / 64'(t);
            absde = (de < 0) ? 64'(-de) : 64'(de);
            m = k * absde;
            if (m >= (64'd1 << 42)) y = 64'(onc_pkg::ZLIMIT);
            else y = (m * 64'(onc_pkg::LOG2E_SCALED)) >> 40;
            if (y > 64'(onc_pkg::ZLIMIT)) y = 64'(onc_pkg::ZLIMIT);
            zo = (de > 0) ? 64'(onc_pkg::ZLIMIT) - y : 64'(onc_pkg::ZLIMIT) + y;
            ip = longint'(zo >> 16) - 64;
            v  = 64'(c_ref) * pow2_frac(zo[15:0]);
            if (c_ref == 0) begin
                res = 0;
            end else if (ip > 24) begin
                res = 64'(onc_pkg::O2_MAX);
            end else begin
                shift = 30 - ip;
                res = (shift >= 64) ? 64'd0 : (v >> shift);
                if (res > 64'(onc_pkg::O2_MAX)) res = 64'(onc_pkg::O2_MAX);
            end
            r.o2 = res[23:0];
            r.status = 1'b0;
            return r;
        endfunction

        function void note_sample(logic [63:0] word);
            pending.push_back(nernst(word[20:0], word[41:21], word[56:42]));
        endfunction

        task report(string what);
            $display("%0t: error: %s", $realtime, what);
            mismatches++;
        endtask

        task check_word(logic [23:0] o2, logic status);
            o2_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word o2=%0d status=%0d", o2, status));
                return;
            end
            e = pending.pop_front();
            if (o2 !== e.o2)
                report($sformatf("o2_percent %0d, expected %0d", o2, e.o2));
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;

    o2_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;

    oxygen_nernst_concentration_top DUT (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_we, .cfg_addr, .cfg_wdata
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // check each result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
    end

    task send_sample(logic [20:0] cell_v, logic [20:0] offs, logic [14:0] t);
        while ($urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, t, offs, cell_v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(s_tdata);
    endtask

    task write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // hold until the pipeline is empty
    task drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task load_window(logic [23:0] k, logic [14:0] tn, logic [23:0] c,
                     logic [21:0] dmin, logic [21:0] dmax,
                     logic [14:0] tmin, logic [14:0] tmax);
        write_reg(onc_pkg::REG_K_NOMINAL, k);
        write_reg(onc_pkg::REG_T_NOMINAL, 24'(tn));
        write_reg(onc_pkg::REG_C_REFERENCE, c);
        write_reg(onc_pkg::REG_DE_MINIMUM, 24'(dmin));
        write_reg(onc_pkg::REG_DE_MAXIMUM, 24'(dmax));
        write_reg(onc_pkg::REG_T_MINIMUM, 24'(tmin));
        write_reg(onc_pkg::REG_T_MAXIMUM, 24'(tmax));
        drain();
    endtask

    // random sample: mostly small voltage differences so the exponent varies
    task random_sample();
        logic [20:0] offs, cell_v;
        logic [14:0] t;
        int          w;
        offs = 21'($urandom);
        w = $urandom_range(20);
        if ($urandom_range(9) < 2) cell_v = 21'($urandom);
        else cell_v = offs + 21'($signed(22'($urandom) & ((22'd1 << w) - 1))
                                - (22'sd1 << w) / 2);
        case ($urandom_range(3))
            0:       t = 15'($urandom);
            1:       t = 15'($urandom_range(3));
            default: t = sb.t_nom + 15'($urandom_range(2000)) - 15'd1000;
        endcase
        send_sample(cell_v, offs, t);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes and exponent clamps at reset settings
        send_sample(21'h0FFFFF, 21'h100000, 15'd0);
        send_sample(21'h100000, 21'h0FFFFF, 15'd32767);
        send_sample(21'd0, 21'd0, 15'd0);
        send_sample(21'd0, 21'd0, 15'd1);
        send_sample(21'd1000, 21'd0, 15'd15568);
        send_sample(-21'sd1000, 21'd0, 15'd15568);
        send_sample(21'd200000, 21'd0, 15'd1);
        send_sample(-21'sd200000, 21'd0, 15'd1);
        send_sample(21'd1, 21'd0, 15'd32767);
        send_sample(21'h1FFFFF, 21'd0, 15'd7784);
        drain();
        load_window(24'hFFFFFF, 15'd1, 24'hFFFFFF, -22'sd100000, 22'sd100000,
                    15'd100, 15'd30000);
        send_sample(-21'sd100000, 21'd0, 15'd100);
        send_sample(21'd100000, 21'd0, 15'd30000);
        send_sample(21'd100001, 21'd0, 15'd200);
        send_sample(21'd5, 21'd0, 15'd99);
        send_sample(21'd5, 21'd0, 15'd30001);
        send_sample(-21'sd3, 21'd0, 15'd32767);
        drain();
        load_window(24'd0, 15'd32767, 24'd0, 22'h200000, 22'h1FFFFF, 15'd0, 15'd32767);
        send_sample(21'd777, 21'd0, 15'd50);
        drain();
        load_window(24'd3126723, 15'd32767, 24'd1, 22'd5000, -22'sd5000, 15'd0, 15'd32767);
        send_sample(21'd0, 21'd0, 15'd50);
        send_sample(21'd0, 21'd0, 15'd0);
        drain();

        // random phases, idling pattern by phase
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 22 : (ph < 4) ? 65 : 0;
            recv_idle = (ph < 2) ? 65 : (ph < 4) ? 22 : 0;
            case (ph)
                0: load_window(onc_pkg::K_NOMINAL_RST, onc_pkg::T_NOMINAL_RST,
                               onc_pkg::C_REFERENCE_RST, onc_pkg::DE_MINIMUM_RST,
                               onc_pkg::DE_MAXIMUM_RST, onc_pkg::T_MINIMUM_RST,
                               onc_pkg::T_MAXIMUM_RST);
                3: load_window(24'($urandom), 15'd32767, 24'($urandom), 22'h200000,
                               22'h1FFFFF, 15'd0, 15'd0);
                5: load_window(24'($urandom), 15'($urandom_range(32767, 1)), 24'($urandom),
                               22'h200000, 22'h1FFFFF, 15'd20000, 15'd100);
                default: load_window(24'($urandom), 15'($urandom_range(32767, 1)),
                                     24'($urandom),
                                     22'(-int'($urandom_range(300000))),
                                     22'($urandom_range(300000)),
                                     15'($urandom_range(2000)),
                                     15'($urandom_range(32767, 20000)));
            endcase
            for (int n = 0; n < 130; n++) begin
                if (ph == 0 && n == 60) drain();
                random_sample();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #50000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
rtl/onc_pkg.sv
rtl/oxygen_nernst_concentration_top.sv
sim/tb.sv
